// ----- rtl/pts_pkg.sv -----
`default_nettype none
// ============================================================================
// pts_pkg
// Types and codes shared by the preemptive priority tick scheduler.
// ============================================================================
package pts_pkg;

    // Operation codes carried by an input beat.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // One input beat: either a slot load or a scheduling tick.
    typedef struct packed {
        logic        opcode;
        logic [3:0]  slot;
        logic [15:0] arrival_time;
        logic [15:0] burst_time;
        logic [7:0]  priority_level;
        logic [15:0] current_time;
    } t_in_item;

    // One result beat, produced by every tick.
    typedef struct packed {
        logic        idle;
        logic [3:0]  chosen_slot;
        logic [15:0] remaining_after;
        logic        finished;
        logic [16:0] completion_time;
        logic [16:0] turnaround_time;
        logic [16:0] delay_time;
    } t_out_item;

    // Tick sequencer states.
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_UPD   = 5'b01000,
        S_RES   = 5'b10000
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/pts_if.sv -----
`default_nettype none
// ============================================================================
// pts_if
// Valid/ready stream interfaces for scheduler input and result beats.
// ============================================================================
interface pts_in_if;
    logic              valid;
    logic              ready;
    pts_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pts_out_if;
    logic               valid;
    logic               ready;
    pts_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/pts_slot_mem.sv -----
`default_nettype none
// ============================================================================
// pts_slot_mem
// Task slot table: one write port, one registered read port, and a valid
// bit per entry so that a slot never written reads back as all zeros.
// ============================================================================
module pts_slot_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 56
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [DW-1:0] o_rd_data
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [DW-1:0] r_rd_data;
    logic          r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    // An entry that was never loaded behaves as a cleared slot.
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule
`default_nettype wire

// ----- rtl/pts_pick_cmp.sv -----
`default_nettype none
// ============================================================================
// pts_pick_cmp
// Shared slot comparator: decides whether the slot just read replaces the
// best candidate found so far in the current scan.
// ============================================================================
module pts_pick_cmp #(
    parameter int TIME_BITS     = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  wire logic [TIME_BITS-1:0]     i_now,
    input  wire logic [TIME_BITS-1:0]     i_cand_arr,
    input  wire logic [TIME_BITS-1:0]     i_cand_rem,
    input  wire logic [PRIORITY_BITS-1:0] i_cand_prio,
    input  wire logic                     i_best_v,
    input  wire logic [TIME_BITS-1:0]     i_best_arr,
    input  wire logic [PRIORITY_BITS-1:0] i_best_prio,
    output logic                          o_take
);
    logic w_eligible;
    logic w_better;

    assign w_eligible = (i_cand_arr <= i_now) && (i_cand_rem != '0);

    // Strict comparisons: slots are scanned in ascending order, so on a full
    // tie the lower slot already held stays chosen.
    assign w_better = (i_cand_prio < i_best_prio) ||
                      ((i_cand_prio == i_best_prio) && (i_cand_arr < i_best_arr));

    assign o_take = w_eligible && (!i_best_v || w_better);

endmodule
`default_nettype wire

// ----- rtl/priority_preemptive_tick_scheduler.sv -----
`default_nettype none
// A load beat writes one task slot as it is accepted and returns no result;
// the block is ready again on the next cycle. A tick beat is accepted in
// S_IDLE; in S_SCAN the sequencer reads the slot table through its single
// read port, one slot per cycle, through one shared comparator; S_DRAIN
// waits for the last registered read; S_UPD writes back the chosen slot and
// registers the completion and turnaround figures; S_RES forms the waiting
// time and loads the result beat. No new beat is accepted until the
// sequencer is back in S_IDLE. A finished result waits in an output
// register, so a load or the next tick can be accepted while it is still
// pending; a tick whose result finds the previous one still waiting holds
// in its last stage until that one is taken.
// ============================================================================
// priority_preemptive_tick_scheduler
// Preemptive priority scheduler that serves one work unit per tick.
// ============================================================================
module priority_preemptive_tick_scheduler #(
    parameter int NUM_SLOTS     = 16,
    parameter int TIME_BITS     = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pts_in_if.sink    i_in,
    pts_out_if.source o_out
);
    import pts_pkg::*;

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int WB = (TIME_BITS + 1 > 17) ? TIME_BITS + 1 : 17;
    localparam int PW = (PRIORITY_BITS > 8) ? PRIORITY_BITS : 8;
    localparam int EW = 3 * TIME_BITS + PRIORITY_BITS;
    localparam logic [SW-1:0] LAST_IDX = SW'(NUM_SLOTS - 1);

    // Entry layout: {priority, arrival, burst, remaining}.
    localparam int REM_LO   = 0;
    localparam int BURST_LO = TIME_BITS;
    localparam int ARR_LO   = 2 * TIME_BITS;
    localparam int PRIO_LO  = 3 * TIME_BITS;

    t_state r_state;
    t_state n_state;

    logic [SW-1:0]            r_idx;
    logic                     r_rd_pend;
    logic [SW-1:0]            r_rd_idx;
    logic [TIME_BITS-1:0]     r_now;

    logic                     r_best_v;
    logic [SW-1:0]            r_best_idx;
    logic [TIME_BITS-1:0]     r_best_arr;
    logic [TIME_BITS-1:0]     r_best_burst;
    logic [TIME_BITS-1:0]     r_best_rem;
    logic [PRIORITY_BITS-1:0] r_best_prio;

    logic                     r_res_idle;
    logic                     r_res_fin;
    logic [TIME_BITS-1:0]     r_res_rem;
    logic [WB-1:0]            r_res_done;
    logic [WB-1:0]            r_res_turn;

    logic                     r_out_valid;
    t_out_item                r_out_data;

    // Input fields brought to the stored widths.
    logic [WB-1:0]            w_arr_ext;
    logic [WB-1:0]            w_burst_ext;
    logic [WB-1:0]            w_now_ext;
    logic [PW-1:0]            w_prio_ext;
    logic [8:0]               w_slot_ext;
    logic [TIME_BITS-1:0]     w_arr_in;
    logic [TIME_BITS-1:0]     w_burst_in;
    logic [TIME_BITS-1:0]     w_now_in;
    logic [PRIORITY_BITS-1:0] w_prio_in;

    logic                     w_accept;
    logic                     w_load;
    logic                     w_out_free;

    logic                     w_wr_en;
    logic [SW-1:0]            w_wr_addr;
    logic [EW-1:0]            w_wr_data;
    logic                     w_rd_en;
    logic [EW-1:0]            w_rd_data;
    logic                     w_take;

    logic [TIME_BITS-1:0]     w_rem_new;
    logic [WB-1:0]            w_wait;
    logic [8:0]               w_chosen_ext;
    logic [WB-1:0]            w_rem_ext;
    t_out_item                w_result;

    assign w_arr_ext   = WB'(i_in.data.arrival_time);
    assign w_burst_ext = WB'(i_in.data.burst_time);
    assign w_now_ext   = WB'(i_in.data.current_time);
    assign w_prio_ext  = PW'(i_in.data.priority_level);
    assign w_slot_ext  = 9'(i_in.data.slot);
    assign w_arr_in    = w_arr_ext[TIME_BITS-1:0];
    assign w_burst_in  = w_burst_ext[TIME_BITS-1:0];
    assign w_now_in    = w_now_ext[TIME_BITS-1:0];
    assign w_prio_in   = w_prio_ext[PRIORITY_BITS-1:0];

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_load     = w_accept && (i_in.data.opcode == OP_LOAD) &&
                        (w_slot_ext < 9'(NUM_SLOTS));
    assign w_out_free = !r_out_valid || o_out.ready;

    // ------------------------------------------------------------------
    // Slot table and shared comparator
    // ------------------------------------------------------------------
    assign w_rem_new = r_best_rem - TIME_BITS'(1);

    always_comb begin
        if (r_state == S_UPD) begin
            w_wr_en   = r_best_v;
            w_wr_addr = r_best_idx;
            w_wr_data = {r_best_prio, r_best_arr, r_best_burst, w_rem_new};
        end else begin
            w_wr_en   = w_load;
            w_wr_addr = w_slot_ext[SW-1:0];
            w_wr_data = {w_prio_in, w_arr_in, w_burst_in, w_burst_in};
        end
    end

    assign w_rd_en = (r_state == S_SCAN);

    pts_slot_mem #(
        .DEPTH (NUM_SLOTS),
        .AW    (SW),
        .DW    (EW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_data)
    );

    pts_pick_cmp #(
        .TIME_BITS     (TIME_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cmp (
        .i_now       (r_now),
        .i_cand_arr  (w_rd_data[ARR_LO +: TIME_BITS]),
        .i_cand_rem  (w_rd_data[REM_LO +: TIME_BITS]),
        .i_cand_prio (w_rd_data[PRIO_LO +: PRIORITY_BITS]),
        .i_best_v    (r_best_v),
        .i_best_arr  (r_best_arr),
        .i_best_prio (r_best_prio),
        .o_take      (w_take)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_in.data.opcode == OP_TICK)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_UPD;
            S_UPD:   n_state = S_RES;
            S_RES: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_pend <= 1'b0;
            r_best_v  <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= (r_state == S_SCAN);
            if (r_state == S_IDLE) begin
                r_idx    <= '0;
                r_best_v <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_idx <= r_idx + SW'(1);
            end
            if (r_rd_pend && w_take) begin
                r_best_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now <= w_now_in;
        end
        r_rd_idx <= r_idx;
        if (r_rd_pend && w_take) begin
            r_best_idx   <= r_rd_idx;
            r_best_arr   <= w_rd_data[ARR_LO +: TIME_BITS];
            r_best_burst <= w_rd_data[BURST_LO +: TIME_BITS];
            r_best_rem   <= w_rd_data[REM_LO +: TIME_BITS];
            r_best_prio  <= w_rd_data[PRIO_LO +: PRIORITY_BITS];
        end
        if (r_state == S_UPD) begin
            r_res_idle <= !r_best_v;
            r_res_fin  <= r_best_v && (w_rem_new == '0);
            r_res_rem  <= w_rem_new;
            r_res_done <= WB'(r_now) + WB'(1);
            r_res_turn <= WB'(r_now) + WB'(1) - WB'(r_best_arr);
        end
    end

    // ------------------------------------------------------------------
    // Result formation and output register
    // ------------------------------------------------------------------
    // Waiting time saturates at zero when ticks run backwards.
    assign w_wait = (r_res_turn >= WB'(r_best_burst)) ?
                    (r_res_turn - WB'(r_best_burst)) : '0;
    assign w_chosen_ext = 9'(r_best_idx);
    assign w_rem_ext    = WB'(r_res_rem);

    always_comb begin
        w_result = '0;
        w_result.idle = r_res_idle;
        if (!r_res_idle) begin
            w_result.chosen_slot     = w_chosen_ext[3:0];
            w_result.remaining_after = w_rem_ext[15:0];
        end
        if (r_res_fin) begin
            w_result.finished        = 1'b1;
            w_result.completion_time = r_res_done[16:0];
            w_result.turnaround_time = r_res_turn[16:0];
            w_result.delay_time      = w_wait[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_RES) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_RES) && w_out_free) begin
            r_out_data <= w_result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

endmodule
`default_nettype wire

// ----- rtl/pts_checker.sv -----
`default_nettype none
// ============================================================================
// pts_checker
// Port-level checks for the tick scheduler, bound to its top level.
// ============================================================================
module pts_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               i_in_ready,
    input wire logic               i_in_opcode,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire pts_pkg::t_out_item i_out_data
);
    import pts_pkg::*;

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its contents.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("result beat changed while stalled");

    // A tick keeps the scheduler busy on the following cycle.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_opcode == OP_TICK) |=> !i_in_ready)
        else $error("input accepted right after a tick");

    // An idle result carries nothing else.
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.idle |->
            (i_out_data.chosen_slot == '0) && (i_out_data.remaining_after == '0) &&
            !i_out_data.finished)
        else $error("idle result carries task fields");

    // Timing figures appear only with a completion, which leaves no work.
    a_finish_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_out_data.finished ? (i_out_data.remaining_after == '0) :
             ((i_out_data.completion_time == '0) && (i_out_data.turnaround_time == '0) &&
              (i_out_data.delay_time == '0))))
        else $error("completion fields inconsistent with finished flag");

endmodule

bind priority_preemptive_tick_scheduler pts_checker u_pts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_opcode (i_in.data.opcode),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
`default_nettype wire
